// ===== rtl/core/mcpwm_pkg.sv =====
package mcpwm_pkg;

  // Fixed field widths of the command and result items
  localparam int ACTION_W   = 2;
  localparam int CHAN_W     = 3;
  localparam int DUTY_W     = 16;
  localparam int PERIOD_W   = 16;
  localparam int USED_W     = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USED_CHANNELS = 1'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_SET_DUTY = 2'd1,
    ACT_START    = 2'd2,
    ACT_STOP     = 2'd3
  } act_t;

  // Per-step command broadcast from the control path to every channel
  typedef struct packed {
    logic step;      // one command item completes this cycle
    logic tick;      // running tick
    logic boundary;  // tick falls on a period boundary
    logic start;     // start from the stopped state
    logic stop;      // stop, all levels low
    logic set_duty;  // accepted duty write
  } chan_cmd_t;

endpackage

// ===== rtl/core/mcpwm_chan.sv =====
module mcpwm_chan #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mcpwm_pkg::chan_cmd_t  cmd,
  input  logic                  active,
  input  logic                  sel,
  input  logic [COUNT_WIDTH-1:0] duty_in,
  output logic                  level_nxt
);
  import mcpwm_pkg::*;

  logic [COUNT_WIDTH-1:0] duty_r, duty_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   level_r;

  // Apply one command item to this channel
  always_comb begin
    duty_nxt  = duty_r;
    cnt_nxt   = cnt_r;
    level_nxt = level_r;
    if (cmd.step) begin
      if (cmd.set_duty && sel) begin
        duty_nxt = duty_in;
      end
      if (cmd.start && active) begin
        cnt_nxt = duty_r;
      end
      if (cmd.tick && active) begin
        // reload a nonzero duty at the boundary, then count down saturating at zero
        if (cmd.boundary && (duty_r != '0)) begin
          level_nxt = 1'b1;
          cnt_nxt   = duty_r;
        end
        if (cnt_nxt != '0) begin
          cnt_nxt = cnt_nxt - COUNT_WIDTH'(1);
        end
        if (cnt_nxt == '0) begin
          level_nxt = 1'b0;
        end
      end
      if (cmd.stop || !active) begin
        level_nxt = 1'b0;
      end
    end
  end

  // Hold channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r  <= '0;
      cnt_r   <= '0;
      level_r <= 1'b0;
    end else begin
      duty_r  <= duty_nxt;
      cnt_r   <= cnt_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

// ===== rtl/core/multi_channel_pwm_generator.sv =====
// Path from input transfer to result transfer: input register, result register.
// Throughput: one command item per cycle unless out_ready stalls the result
// register; all channel counters update in parallel in the single step
// between the two registers.
// Reset (rst_n low, synchronous): stopped, all levels low, counters and
// stored duties zero, period_ticks 1, used_channels 0.
module multi_channel_pwm_generator #(
  parameter int CHANNELS    = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [mcpwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcpwm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // command channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mcpwm_pkg::ACTION_W-1:0]     in_action,
  input  logic [mcpwm_pkg::CHAN_W-1:0]       in_channel,
  input  logic [mcpwm_pkg::DUTY_W-1:0]       in_duty_ticks,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [CHANNELS-1:0]                out_levels,
  output logic                               out_is_running,
  output logic                               out_rejected
);
  import mcpwm_pkg::*;

  localparam int CMP_W = 5;
  localparam logic [CMP_W-1:0] CH_LIMIT = CMP_W'(CHANNELS);

  // configuration registers
  logic [PERIOD_W-1:0] period_ticks_r;
  logic [USED_W-1:0]   used_channels_r;

  // input stage
  logic                s1_valid_r;
  act_t                s1_action_r;
  logic [CHAN_W-1:0]   s1_chan_r;
  logic [DUTY_W-1:0]   s1_duty_r;

  // shared state
  logic [COUNT_WIDTH-1:0] period_count_r, period_count_nxt;
  logic                   run_r, run_nxt;

  // result stage
  logic                out_valid_r;
  logic [CHANNELS-1:0] out_levels_r;
  logic                out_is_running_r;
  logic                out_rejected_r;

  logic                adv;
  logic                rejected_nxt;
  chan_cmd_t           cmd;
  logic [CHANNELS-1:0] active;
  logic [CHANNELS-1:0] sel;
  logic [CHANNELS-1:0] level_nxt;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_ticks_r  <= PERIOD_W'(1);
      used_channels_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PERIOD_TICKS) begin
        period_ticks_r <= cfg_wdata[PERIOD_W-1:0];
      end else if (cfg_index == CFG_USED_CHANNELS) begin
        used_channels_r <= cfg_wdata[USED_W-1:0];
      end
    end
  end

  // Advance the held item when the result register is free
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  // Capture the command item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= act_t'(in_action);
      s1_chan_r   <= in_channel;
      s1_duty_r   <= in_duty_ticks;
    end
  end

  // Decode the command into shared state changes and channel controls
  always_comb begin
    period_count_nxt = period_count_r;
    run_nxt          = run_r;
    rejected_nxt     = 1'b0;
    cmd              = '0;
    cmd.step         = adv;
    if (adv) begin
      unique case (s1_action_r)
        ACT_TICK: begin
          if (run_r) begin
            cmd.tick     = 1'b1;
            cmd.boundary = (period_count_r <= COUNT_WIDTH'(1));
            if (cmd.boundary) begin
              period_count_nxt = COUNT_WIDTH'(period_ticks_r);
            end else begin
              period_count_nxt = period_count_r - COUNT_WIDTH'(1);
            end
          end
        end
        ACT_SET_DUTY: begin
          if (({2'b00, s1_chan_r} < {1'b0, used_channels_r}) &&
              ({2'b00, s1_chan_r} < CH_LIMIT) &&
              (s1_duty_r <= period_ticks_r)) begin
            cmd.set_duty = 1'b1;
          end else begin
            rejected_nxt = 1'b1;
          end
        end
        ACT_START: begin
          if (!run_r) begin
            cmd.start        = 1'b1;
            period_count_nxt = COUNT_WIDTH'(period_ticks_r);
            run_nxt          = 1'b1;
          end
        end
        ACT_STOP: begin
          cmd.stop = 1'b1;
          run_nxt  = 1'b0;
        end
        default: begin
          cmd.stop = 1'b0;
        end
      endcase
    end
  end

  // Hold period counter and run flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_count_r <= '0;
      run_r          <= 1'b0;
    end else begin
      period_count_r <= period_count_nxt;
      run_r          <= run_nxt;
    end
  end

  // Channel lanes
  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    assign active[i] = ({1'b0, used_channels_r} > CMP_W'(i));
    assign sel[i]    = ({2'b00, s1_chan_r} == CMP_W'(i));

    mcpwm_chan #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_chan (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .active   (active[i]),
      .sel      (sel[i]),
      .duty_in  (COUNT_WIDTH'(s1_duty_r)),
      .level_nxt(level_nxt[i])
    );
  end

  // Result register; drop the result once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_levels_r     <= level_nxt;
      out_is_running_r <= run_nxt;
      out_rejected_r   <= rejected_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_levels     = out_levels_r;
  assign out_is_running = out_is_running_r;
  assign out_rejected   = out_rejected_r;

endmodule

// ===== tb/tb_multi_channel_pwm_generator.sv =====
module tb_multi_channel_pwm_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import mcpwm_pkg::*;

  localparam int NUM_CH       = 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 110;

  // One result item as seen on the output channel
  typedef struct {
    logic [NUM_CH-1:0] levels;
    logic              running;
    logic              rejected;
  } pwm_result_t;

  // Tracks the generator state and checks results in order
  class pwm_scoreboard;
    logic [PERIOD_W-1:0] period_len;
    logic [USED_W-1:0]   used_count;
    logic [DUTY_W-1:0]   period_left;
    logic [DUTY_W-1:0]   on_left [NUM_CH];
    logic [DUTY_W-1:0]   duty_val [NUM_CH];
    bit                  running;
    logic [NUM_CH-1:0]   level_q;
    pwm_result_t         expected_levels [$];
    int unsigned         mismatches;
    int unsigned         commands;
    int unsigned         checked;
    int unsigned         rejects;
    int unsigned         boundaries;
    int unsigned         high_seen;

    function new();
      period_len  = 1;
      used_count  = 0;
      period_left = 0;
      running     = 0;
      level_q     = '0;
      for (int i = 0; i < NUM_CH; i++) begin
        on_left[i]  = '0;
        duty_val[i] = '0;
      end
      mismatches = 0;
      commands   = 0;
      checked    = 0;
      rejects    = 0;
      boundaries = 0;
      high_seen  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PERIOD_TICKS:  period_len = data[PERIOD_W-1:0];
        CFG_USED_CHANNELS: used_count = data[USED_W-1:0];
        default: ;
      endcase
    endfunction

    // Counts above the channel total act as all channels
    function int live_channels();
      return (used_count > NUM_CH) ? NUM_CH : int'(used_count);
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    // Count the period down, reload on a boundary, then run the on-counters
    function void advance_tick();
      int n;
      n = live_channels();
      if (period_left <= 1) begin
        for (int i = 0; i < n; i++) begin
          if (duty_val[i] != 0) begin
            level_q[i] = 1'b1;
            on_left[i] = duty_val[i];
          end
        end
        period_left = period_len;
        boundaries++;
      end else begin
        period_left = period_left - 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        if (on_left[i] != 0) on_left[i] = on_left[i] - 1'b1;
        if (on_left[i] == 0) level_q[i] = 1'b0;
      end
    endfunction

    // Apply one accepted command and queue the result it produces
    function void note_command(act_t act, logic [CHAN_W-1:0] ch, logic [DUTY_W-1:0] duty);
      pwm_result_t r;
      bit          refused;
      int          n;
      refused = 0;
      n = live_channels();
      commands++;
      case (act)
        ACT_TICK: begin
          if (running) advance_tick();
        end
        ACT_SET_DUTY: begin
          if (int'(ch) >= n || duty > period_len) begin
            refused = 1;
            rejects++;
          end else begin
            duty_val[ch] = duty;
          end
        end
        ACT_START: begin
          if (!running) begin
            period_left = period_len;
            for (int i = 0; i < n; i++) on_left[i] = duty_val[i];
            running = 1;
          end
        end
        default: begin
          level_q = '0;
          running = 0;
        end
      endcase
      // unused channels always read low
      for (int i = 0; i < NUM_CH; i++) begin
        if (i >= n) level_q[i] = 1'b0;
      end
      r.levels   = level_q;
      r.running  = running;
      r.rejected = refused;
      if (level_q != 0) high_seen++;
      expected_levels.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [NUM_CH-1:0] levels, logic running_bit,
                               logic rejected_bit);
      pwm_result_t want;
      if (expected_levels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual levels %0h run %0b rej %0b",
                 $time, levels, running_bit, rejected_bit);
        return;
      end
      want = expected_levels.pop_front();
      checked++;
      compare_field("levels", want.levels, levels);
      compare_field("is_running", want.running, running_bit);
      compare_field("rejected", want.rejected, rejected_bit);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ACTION_W-1:0]   in_action = ACT_TICK;
  logic [CHAN_W-1:0]     in_channel = '0;
  logic [DUTY_W-1:0]     in_duty_ticks = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [NUM_CH-1:0]     out_levels;
  logic                  out_is_running;
  logic                  out_rejected;

  bit                    calm = 0;
  int unsigned           quiet_cycles = 0;
  pwm_scoreboard         sb;

  multi_channel_pwm_generator #(
    .CHANNELS    (NUM_CH),
    .COUNT_WIDTH (16)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_channel     (in_channel),
    .in_duty_ticks  (in_duty_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_levels     (out_levels),
    .out_is_running (out_is_running),
    .out_rejected   (out_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random unless in a calm stretch
  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
  end

  // Record transfers on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_command(act_t'(in_action), in_channel, in_duty_ticks);
      if (out_valid && out_ready)
        sb.check_result(out_levels, out_is_running, out_rejected);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one command, with an optional gap, and hold it until transfer
  task automatic send_cmd(act_t act, logic [CHAN_W-1:0] ch, logic [DUTY_W-1:0] duty);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_channel    <= ch;
    in_duty_ticks <= duty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has been checked
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(int unsigned period, int unsigned used);
    drain();
    write_reg(CFG_PERIOD_TICKS, CFG_DATA_W'(period));
    write_reg(CFG_USED_CHANNELS, CFG_DATA_W'(used));
  endtask

  // Random commands: mostly duty writes and ticks while running
  task automatic run_phase(int unsigned items);
    int unsigned done;
    int unsigned pick;
    int unsigned sel;
    act_t        act;
    logic [CHAN_W-1:0] ch;
    logic [DUTY_W-1:0] duty;
    bit          ignored;
    done = 0;
    while (done < items) begin
      pick = $urandom_range(99);
      if (!sb.running) begin
        if (pick < 40)      act = ACT_START;
        else if (pick < 70) act = ACT_SET_DUTY;
        else if (pick < 85) act = ACT_TICK;
        else                act = ACT_STOP;
      end else begin
        if (pick < 66)      act = ACT_TICK;
        else if (pick < 90) act = ACT_SET_DUTY;
        else if (pick < 96) act = ACT_START;
        else                act = ACT_STOP;
      end
      ch  = CHAN_W'($urandom_range(NUM_CH - 1));
      sel = $urandom_range(9);
      if (sel < 7)       duty = DUTY_W'($urandom_range(int'(sb.period_len)));
      else if (sel == 7) duty = sb.period_len;
      else               duty = DUTY_W'($urandom);
      ignored = (act == ACT_TICK && !sb.running) || (act == ACT_START && sb.running);
      send_cmd(act, ch, duty);
      if (!ignored) done++;
    end
  endtask

  initial begin
    int unsigned period;
    int unsigned used;
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: no channels in use
    send_cmd(ACT_TICK, 3'd0, 16'd0);
    send_cmd(ACT_SET_DUTY, 3'd0, 16'd0);
    send_cmd(ACT_START, 3'd7, 16'hffff);
    send_cmd(ACT_START, 3'd0, 16'd0);
    send_cmd(ACT_TICK, 3'd0, 16'd0);
    send_cmd(ACT_STOP, 3'd0, 16'd0);

    // Short period, all channels: duty at the limit, over it, and duty of one
    program_regs(4, 8);
    send_cmd(ACT_SET_DUTY, 3'd7, 16'd4);
    send_cmd(ACT_SET_DUTY, 3'd0, 16'hffff);
    send_cmd(ACT_SET_DUTY, 3'd1, 16'd3);
    send_cmd(ACT_SET_DUTY, 3'd2, 16'd1);
    send_cmd(ACT_SET_DUTY, 3'd3, 16'd2);
    send_cmd(ACT_START, 3'd0, 16'd0);
    repeat (7) send_cmd(ACT_TICK, 3'd0, 16'd0);
    send_cmd(ACT_STOP, 3'd0, 16'd0);

    // Zero period and a channel count above the channel total
    program_regs(0, 12);
    send_cmd(ACT_SET_DUTY, 3'd5, 16'd0);
    send_cmd(ACT_START, 3'd0, 16'd0);
    repeat (2) send_cmd(ACT_TICK, 3'd0, 16'd0);
    send_cmd(ACT_STOP, 3'd0, 16'd0);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin period = 1;     used = 8; end
        1: begin period = 65535; used = 8; end
        2: begin period = 3;     used = 0; end
        3: begin period = 8;     used = 4; end
        default: begin
          period = $urandom_range(16, 2);
          used   = $urandom_range(8, 1);
        end
      endcase
      program_regs(period, used);
      calm = (ph == 3);
      run_phase(PHASE_ITEMS);
      calm = 0;
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Ran %0d commands over %0d register settings, %0d results checked",
             sb.commands, NUM_PHASES + 3, sb.checked);
    $display("Saw %0d period boundaries, %0d refused duty writes, %0d results with a level high",
             sb.boundaries, sb.rejects, sb.high_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
